>>> rtl/core/cidr_allow_list_match_macros.svh
// Assertion macros used by the checker file of the access-list matcher.
`ifndef CIDR_ALLOW_LIST_MATCH_MACROS_SVH
`define CIDR_ALLOW_LIST_MATCH_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet in reset.
`define CAL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle property failed");

// Next-cycle implication, sampled on the rising clock edge, quiet in reset.
`define CAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle property failed");

`endif

>>> rtl/core/cal_pkg.sv
// Types, constants and codes shared by the access-list matcher files.
package cal_pkg;

    localparam int MAX_RULES = 16;
    localparam int SLOT_W    = $clog2(MAX_RULES);
    localparam int COUNT_W   = 5;

    localparam logic       REQ_WRITE = 1'b0;
    localparam logic       REQ_CHECK = 1'b1;
    localparam logic [1:0] FAM_IPV4  = 2'd0;
    localparam logic [1:0] FAM_IPV6  = 2'd1;

    localparam logic [7:0]  V4_MAX_PREFIX = 8'd32;
    localparam logic [7:0]  V6_MAX_PREFIX = 8'd128;
    localparam logic [7:0]  MAPPED_PREFIX = 8'd96;
    localparam logic [31:0] MAPPED_TAG    = 32'h0000_ffff;

    typedef struct packed {
        logic        req_type;
        logic [1:0]  addr_family;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [7:0]  prefix_len;
        logic [3:0]  rule_index;
    } t_req;

    typedef struct packed {
        logic allowed;
        logic rule_error;
    } t_rsp;

    typedef struct packed {
        logic        is_v6;
        logic [7:0]  prefix;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

endpackage

>>> rtl/core/cal_match.sv
// Compares one stored prefix rule against the normalised peer address.
module cal_match (
    input  cal_pkg::t_entry i_entry,
    input  logic            i_key_v6,
    input  logic [63:0]     i_key_high,
    input  logic [63:0]     i_key_low,
    output logic            o_hit
);

    logic [31:0] mask_v4;
    logic [63:0] mask_high;
    logic [63:0] mask_low;
    logic [7:0]  low_bits;
    logic        v4_hit;
    logic        v6_hit;

    // A right shift of all ones by the prefix leaves the host bits set;
    // shifts of the full width or more give an all-ones mask.
    always_comb begin
        low_bits  = (i_entry.prefix > 8'd64) ? (i_entry.prefix - 8'd64) : 8'd0;
        mask_v4   = ~({32{1'b1}} >> i_entry.prefix);
        mask_high = ~({64{1'b1}} >> i_entry.prefix);
        mask_low  = ~({64{1'b1}} >> low_bits);
        v4_hit    = ((i_entry.addr_low[31:0] ^ i_key_low[31:0]) & mask_v4) == 32'd0;
        v6_hit    = (((i_entry.addr_high ^ i_key_high) & mask_high) == 64'd0) &&
                    (((i_entry.addr_low ^ i_key_low) & mask_low) == 64'd0);
        if (i_entry.is_v6 != i_key_v6) begin
            o_hit = 1'b0;
        end else if (i_key_v6) begin
            o_hit = v6_hit;
        end else begin
            o_hit = v4_hit;
        end
    end

endmodule

>>> rtl/core/cidr_allow_list_match.sv
// Rule writes and bypassed checks (no rules, or a non-IP family) answer the cycle after the beat.
// A scanning check reads one rule a cycle from the table RAM in ST_SCAN, compares the last in
// ST_DRAIN and answers with a registered beat; busy stays high until then. Back-to-back writes
// run at one per cycle while busy is low. The receiver cannot stall the result strobe.
// Synchronous active-low reset clears rule_count and control; the rule table keeps its contents.
module cidr_allow_list_match (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  cal_pkg::t_req               i_req,
    output logic                        o_busy,
    output logic                        o_done,
    output cal_pkg::t_rsp               o_rsp,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cal_pkg::COUNT_W-1:0] i_cfg_data
);

    cal_pkg::t_state r_state;
    cal_pkg::t_state n_state;

    logic [cal_pkg::COUNT_W-1:0] r_rule_count;
    logic [cal_pkg::SLOT_W-1:0]  r_idx;
    logic [cal_pkg::SLOT_W-1:0]  n_idx;
    logic [cal_pkg::SLOT_W-1:0]  r_last;
    logic [cal_pkg::SLOT_W-1:0]  n_last;
    logic                        r_cmp_vld;
    logic                        r_hit;
    logic                        n_hit;
    logic                        r_key_v6;
    logic [63:0]                 r_key_high;
    logic [63:0]                 r_key_low;
    logic                        r_done;
    logic                        n_done;
    cal_pkg::t_rsp               r_rsp;
    cal_pkg::t_rsp               n_rsp;

    cal_pkg::t_entry mem [cal_pkg::MAX_RULES];
    cal_pkg::t_entry r_rd_data;
    cal_pkg::t_entry wr_entry;

    logic accept;
    logic is_write;
    logic is_mapped;
    logic fam_bad;
    logic plen_bad;
    logic idx_bad;
    logic wr_err;
    logic mem_we;
    logic bypass;
    logic scanning;
    logic draining;
    logic cmp_hit;

    // Control outputs decoded from the state.
    always_comb begin
        o_busy   = 1'b1;
        scanning = 1'b0;
        draining = 1'b0;
        case (r_state)
            cal_pkg::ST_IDLE:  o_busy   = 1'b0;
            cal_pkg::ST_SCAN:  scanning = 1'b1;
            cal_pkg::ST_DRAIN: draining = 1'b1;
            default:           o_busy   = 1'b1;
        endcase
    end

    assign o_cfg_ready = !o_busy;
    assign accept      = i_start && !o_busy;
    assign is_write    = i_req.req_type == cal_pkg::REQ_WRITE;
    assign is_mapped   = (i_req.addr_high == 64'd0) &&
                         (i_req.addr_low[63:32] == cal_pkg::MAPPED_TAG);

    // Rule write: validate, then fold a v4-mapped IPv6 rule into an IPv4 one.
    always_comb begin
        fam_bad  = (i_req.addr_family != cal_pkg::FAM_IPV4) &&
                   (i_req.addr_family != cal_pkg::FAM_IPV6);
        plen_bad = (i_req.addr_family == cal_pkg::FAM_IPV6) ?
                   (i_req.prefix_len > cal_pkg::V6_MAX_PREFIX) :
                   (i_req.prefix_len > cal_pkg::V4_MAX_PREFIX);
        idx_bad  = {1'b0, i_req.rule_index} >= 5'(cal_pkg::MAX_RULES);
        wr_err   = fam_bad || plen_bad || idx_bad;
        wr_entry.addr_high = 64'd0;
        wr_entry.addr_low  = {32'd0, i_req.addr_low[31:0]};
        wr_entry.is_v6     = 1'b0;
        wr_entry.prefix    = i_req.prefix_len;
        if (i_req.addr_family == cal_pkg::FAM_IPV6) begin
            if ((i_req.prefix_len >= cal_pkg::MAPPED_PREFIX) && is_mapped) begin
                wr_entry.prefix = i_req.prefix_len - cal_pkg::MAPPED_PREFIX;
            end else begin
                wr_entry.is_v6     = 1'b1;
                wr_entry.addr_high = i_req.addr_high;
                wr_entry.addr_low  = i_req.addr_low;
            end
        end
    end

    assign mem_we = accept && is_write && !wr_err;
    assign bypass = (r_rule_count == '0) ||
                    ((i_req.addr_family != cal_pkg::FAM_IPV4) &&
                     (i_req.addr_family != cal_pkg::FAM_IPV6));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[i_req.rule_index[cal_pkg::SLOT_W-1:0]] <= wr_entry;
        end
        r_rd_data <= mem[r_idx];
    end

    cal_match u_match (
        .i_entry    (r_rd_data),
        .i_key_v6   (r_key_v6),
        .i_key_high (r_key_high),
        .i_key_low  (r_key_low),
        .o_hit      (cmp_hit)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            cal_pkg::ST_IDLE: begin
                if (accept && !is_write && !bypass) begin
                    n_state = cal_pkg::ST_SCAN;
                end
            end
            cal_pkg::ST_SCAN: begin
                if (r_idx == r_last) begin
                    n_state = cal_pkg::ST_DRAIN;
                end
            end
            cal_pkg::ST_DRAIN: n_state = cal_pkg::ST_IDLE;
            default:           n_state = cal_pkg::ST_IDLE;
        endcase
    end

    // Scan pointer, running hit and the result beat.
    always_comb begin
        n_idx  = r_idx;
        n_last = r_last;
        n_hit  = r_hit;
        n_done = 1'b0;
        n_rsp  = '0;
        if (r_cmp_vld && cmp_hit) begin
            n_hit = 1'b1;
        end
        if (scanning) begin
            n_idx = r_idx + 1'b1;
        end
        if (accept) begin
            n_idx = '0;
            n_hit = 1'b0;
            if (r_rule_count >= cal_pkg::COUNT_W'(cal_pkg::MAX_RULES)) begin
                n_last = cal_pkg::SLOT_W'(cal_pkg::MAX_RULES - 1);
            end else begin
                n_last = cal_pkg::SLOT_W'(r_rule_count - 1'b1);
            end
            if (is_write) begin
                n_done           = 1'b1;
                n_rsp.rule_error = wr_err;
            end else if (bypass) begin
                n_done        = 1'b1;
                n_rsp.allowed = 1'b1;
            end
        end
        if (draining) begin
            // The last rule is being compared in this cycle.
            n_done        = 1'b1;
            n_rsp.allowed = r_hit || cmp_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cal_pkg::ST_IDLE;
            r_rule_count <= '0;
            r_idx        <= '0;
            r_last       <= '0;
            r_cmp_vld    <= 1'b0;
            r_hit        <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_last    <= n_last;
            r_cmp_vld <= scanning;
            r_hit     <= n_hit;
            r_done    <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_rule_count <= i_cfg_data;
            end
        end
    end

    // The check key is unwrapped from a v4-mapped address before the scan.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key_v6   <= (i_req.addr_family == cal_pkg::FAM_IPV6) && !is_mapped;
            r_key_high <= i_req.addr_high;
            r_key_low  <= i_req.addr_low;
        end
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

>>> rtl/core/cal_chk.sv
// Port-level checker for the access-list matcher, bound to the top level.
`include "cidr_allow_list_match_macros.svh"

module cal_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_start,
    input cal_pkg::t_req i_req,
    input logic          o_busy,
    input logic          o_done,
    input cal_pkg::t_rsp o_rsp
);

    logic acc_write;
    logic acc_other;

    assign acc_write = i_start && !o_busy && (i_req.req_type == cal_pkg::REQ_WRITE);
    assign acc_other = i_start && !o_busy && (i_req.req_type == cal_pkg::REQ_CHECK) &&
                       (i_req.addr_family != cal_pkg::FAM_IPV4) &&
                       (i_req.addr_family != cal_pkg::FAM_IPV6);

    // A rule write answers in the next cycle and never allows.
    `CAL_ASSERT_NEXT(a_write_answers, i_clk, i_rst_n, acc_write, o_done && !o_rsp.allowed)
    // A check of a non-IP peer is allowed in the next cycle without error.
    `CAL_ASSERT_NEXT(a_other_allowed, i_clk, i_rst_n, acc_other,
                     o_done && o_rsp.allowed && !o_rsp.rule_error)
    // A refused write is never reported as allowed.
    `CAL_ASSERT_SAME(a_err_not_allowed, i_clk, i_rst_n, o_done && o_rsp.rule_error,
                     !o_rsp.allowed)
    // The result beat only appears once the scan has finished.
    `CAL_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, o_done, !o_busy)

endmodule

bind cidr_allow_list_match cal_chk u_cal_chk (.*);
